FILE: rtl/voronoi_two_nearest_border_macros.svh
// Assertion macros used by the checker file.
`ifndef VORONOI_TWO_NEAREST_BORDER_MACROS_SVH
`define VORONOI_TWO_NEAREST_BORDER_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define VTNB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vtnb: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define VTNB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vtnb: next-cycle check failed");

// Same-cycle implication that also holds across reset.
`define VTNB_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("vtnb: reset-time check failed");

`endif

FILE: rtl/vtnb_pkg.sv
package vtnb_pkg;

   // Field and store geometry
   localparam int MAX_SEEDS = 64;
   localparam int MAX_DIM   = 1024;
   localparam int NEIGHBORS = 9;
   localparam int COORD_W   = 10;
   localparam int DIM_W     = 11;
   localparam int SEED_W    = 6;
   localparam int CNT_W     = 7;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int DIST_W    = SQ_W + 1;
   localparam int SEED_DW   = 2 * COORD_W;
   localparam int REM_SHD_W = DIM_W + COORD_W - 1;
   localparam int REM_CNT_W = $clog2(COORD_W + 1);
   localparam int NB_W      = $clog2(NEIGHBORS);

   // Opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register indexes
   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_SEED_COUNT  = 2'd2;

   // Neighbor walk: center first, then 0..8 without the center
   localparam logic [NB_W-1:0] NB_FIRST  = 4'd0;
   localparam logic [NB_W-1:0] NB_BEFORE = 4'd3;
   localparam logic [NB_W-1:0] NB_CENTER = 4'd4;
   localparam logic [NB_W-1:0] NB_AFTER  = 4'd5;
   localparam logic [NB_W-1:0] NB_LAST   = 4'd8;

   // Axis offset codes
   localparam logic [1:0] OFF_MINUS = 2'd0;
   localparam logic [1:0] OFF_ZERO  = 2'd1;
   localparam logic [1:0] OFF_PLUS  = 2'd2;

   // Control from the sequencer into the distance unit
   typedef struct packed {
      logic              clear;
      logic              valid;
      logic [SEED_W-1:0] idx;
      logic              last;
   } scan_ctl_type;

   // Outcome of one scan
   typedef struct packed {
      logic              done;
      logic [SEED_W-1:0] first;
      logic [SEED_W-1:0] second;
   } scan_res_type;

   // Zero acts as one, oversize saturates
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      else r = v;
      return r;
   endfunction

   // Last seed index scanned
   function automatic logic [SEED_W-1:0] last_seed(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] s;
      if (v == '0) s = CNT_W'(1);
      else if (v > CNT_W'(MAX_SEEDS)) s = CNT_W'(MAX_SEEDS);
      else s = v;
      s = s - CNT_W'(1);
      return s[SEED_W-1:0];
   endfunction

   function automatic logic [1:0] nb_dx(input logic [NB_W-1:0] k);
      logic [1:0] r;
      case (k)
         4'd0, 4'd3, 4'd6: r = OFF_MINUS;
         4'd2, 4'd5, 4'd8: r = OFF_PLUS;
         default:          r = OFF_ZERO;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] nb_dy(input logic [NB_W-1:0] k);
      logic [1:0] r;
      case (k)
         4'd0, 4'd1, 4'd2: r = OFF_MINUS;
         4'd6, 4'd7, 4'd8: r = OFF_PLUS;
         default:          r = OFF_ZERO;
      endcase
      return r;
   endfunction

   // Step one cell along an axis of n cells, wrapping at both ends (c < n)
   function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                     input logic [1:0] off,
                                                     input logic [DIM_W-1:0] n);
      logic [DIM_W-1:0]   top_v;
      logic [COORD_W-1:0] r;
      top_v = n - DIM_W'(1);
      case (off)
         OFF_MINUS: r = (c == '0) ? top_v[COORD_W-1:0] : c - COORD_W'(1);
         OFF_PLUS:  r = ({1'b0, c} == top_v) ? '0 : c + COORD_W'(1);
         default:   r = c;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/vtnb_if.sv
// Request channel: seed loads and cell queries
interface vtnb_req_if;
   import vtnb_pkg::*;
   logic               valid;
   logic               ready;
   logic               op;
   logic [SEED_W-1:0]  seed_index;
   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;

   modport source (output valid, op, seed_index, col, row, input ready);
   modport sink   (input valid, op, seed_index, col, row, output ready);
endinterface

// Response channel: one word per query
interface vtnb_rsp_if;
   import vtnb_pkg::*;
   logic              valid;
   logic              ready;
   logic [SEED_W-1:0] nearest_seed;
   logic [SEED_W-1:0] second_seed;
   logic              on_border;

   modport source (output valid, nearest_seed, second_seed, on_border, input ready);
   modport sink   (input valid, nearest_seed, second_seed, on_border, output ready);
endinterface

FILE: rtl/voronoi_two_nearest_border.sv
// Seed load: written to the seed RAM, no response word; loads can follow back to back.
// Query: two modulo reductions of the coordinates, then up to nine seed scans through one
// distance unit (fewer when a border shows up early). Req ready only while idle, so a new
// query is taken only once the last response is loaded; a finished response waits while
// the previous word is still unread. Reset: grid 1024 x 1024, 64 seeds, sequencer idle,
// no response; seed RAM not cleared.
module voronoi_two_nearest_border (
   input  logic                           clock,
   input  logic                           reset,
   vtnb_req_if.sink                       req_ch,
   vtnb_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [vtnb_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [vtnb_pkg::DIM_W-1:0]     csr_wdata
);
   import vtnb_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RED_X = 3'd1;
   localparam logic [2:0] ST_RED_Y = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [DIM_W-1:0]   grid_width_ff, grid_width_in, grid_height_ff, grid_height_in;
   logic [CNT_W-1:0]   seed_count_ff, seed_count_in;
   logic [DIM_W-1:0]   w_eff, h_eff;
   logic [SEED_W-1:0]  s_last;
   logic               req_accept, out_load;

   logic [COORD_W-1:0] row_ff, row_in, x_ff, x_in, y_ff, y_in, qx_ff, qx_in, qy_ff, qy_in;
   logic [NB_W-1:0]    k_ff, k_in;
   logic               center_ff, center_in, border_ff, border_in;
   logic [SEED_W-1:0]  n1_ff, n1_in, n2_ff, n2_in;
   logic [SEED_W-1:0]  scan_idx_ff, scan_idx_in;
   logic               iss_valid_ff, iss_valid_in, iss_last_ff, iss_last_in;
   logic [SEED_W-1:0]  iss_idx_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SEED_W-1:0]  rsp_n1_ff, rsp_n1_in, rsp_n2_ff, rsp_n2_in;
   logic               rsp_border_ff, rsp_border_in;

   logic               rem_start, rem_done;
   logic [COORD_W-1:0] rem_dividend, rem_q;
   logic [DIM_W-1:0]   rem_divisor;
   logic [SEED_DW-1:0] seed_rdata;
   scan_ctl_type       scan_ctl;
   scan_res_type       scan_res;

   // Effective configuration
   assign w_eff  = clamp_dim(grid_width_ff);
   assign h_eff  = clamp_dim(grid_height_ff);
   assign s_last = last_seed(seed_count_ff);

   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Configuration writes
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      seed_count_in  = seed_count_ff;
      if (csr_we) begin
         case (csr_index)
            REG_GRID_WIDTH:  grid_width_in  = csr_wdata;
            REG_GRID_HEIGHT: grid_height_in = csr_wdata;
            REG_SEED_COUNT:  seed_count_in  = csr_wdata[CNT_W-1:0];
            default:         ;
         endcase
      end
   end

   // Seed store: {col, row} per slot
   vtnb_ram #(.WIDTH(SEED_DW), .DEPTH(MAX_SEEDS)) u_seed_ram (
      .clock (clock),
      .we    (req_accept && (req_ch.op == OP_LOAD)),
      .waddr (req_ch.seed_index),
      .wdata ({req_ch.col, req_ch.row}),
      .raddr (scan_idx_ff),
      .rdata (seed_rdata)
   );

   // Modulo reduction of the query coordinates
   assign rem_dividend = (state_ff == ST_IDLE) ? req_ch.col : row_ff;
   assign rem_divisor  = (state_ff == ST_IDLE) ? w_eff : h_eff;

   vtnb_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .done      (rem_done),
      .remainder (rem_q)
   );

   // Distance unit, fed in step with the RAM read data
   assign scan_ctl.clear = (state_ff == ST_SETUP);
   assign scan_ctl.valid = iss_valid_ff;
   assign scan_ctl.idx   = iss_idx_ff;
   assign scan_ctl.last  = iss_last_ff;

   vtnb_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .query_col (qx_ff),
      .query_row (qy_ff),
      .seed_col  (seed_rdata[SEED_DW-1:COORD_W]),
      .seed_row  (seed_rdata[COORD_W-1:0]),
      .res       (scan_res)
   );

   assign out_load = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      k_in          = k_ff;
      center_in     = center_ff;
      border_in     = border_ff;
      n1_in         = n1_ff;
      n2_in         = n2_ff;
      scan_idx_in   = scan_idx_ff;
      iss_valid_in  = 1'b0;
      iss_last_in   = 1'b0;
      rem_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_n1_in     = rsp_n1_ff;
      rsp_n2_in     = rsp_n2_ff;
      rsp_border_in = rsp_border_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_ch.op == OP_QUERY)) begin
               row_in    = req_ch.row;
               rem_start = 1'b1;
               state_in  = ST_RED_X;
            end
         end
         ST_RED_X: begin
            if (rem_done) begin
               x_in      = rem_q;
               rem_start = 1'b1;
               state_in  = ST_RED_Y;
            end
         end
         ST_RED_Y: begin
            if (rem_done) begin
               y_in      = rem_q;
               k_in      = NB_CENTER;
               center_in = 1'b1;
               border_in = 1'b0;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // Neighbor position for this scan; the distance unit is cleared now
            qx_in       = wrap_coord(x_ff, nb_dx(k_ff), w_eff);
            qy_in       = wrap_coord(y_ff, nb_dy(k_ff), h_eff);
            scan_idx_in = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            iss_valid_in = 1'b1;
            iss_last_in  = (scan_idx_ff == s_last);
            if (scan_idx_ff == s_last) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + SEED_W'(1);
            end
         end
         ST_DRAIN: begin
            if (scan_res.done) begin
               if (center_ff) begin
                  n1_in     = scan_res.first;
                  n2_in     = scan_res.second;
                  center_in = 1'b0;
                  k_in      = NB_FIRST;
                  state_in  = ST_SETUP;
               end else if (scan_res.first != n1_ff) begin
                  border_in = 1'b1;
                  state_in  = ST_DONE;
               end else if (k_ff == NB_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  // the center cell matches itself, skip it
                  k_in     = (k_ff == NB_BEFORE) ? NB_AFTER : k_ff + NB_W'(1);
                  state_in = ST_SETUP;
               end
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_n1_in     = n1_ff;
               rsp_n2_in     = n2_ff;
               rsp_border_in = border_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         grid_width_ff  <= DIM_W'(MAX_DIM);
         grid_height_ff <= DIM_W'(MAX_DIM);
         seed_count_ff  <= CNT_W'(MAX_SEEDS);
         iss_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         seed_count_ff  <= seed_count_in;
         iss_valid_ff   <= iss_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      row_ff        <= row_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      k_ff          <= k_in;
      center_ff     <= center_in;
      border_ff     <= border_in;
      n1_ff         <= n1_in;
      n2_ff         <= n2_in;
      scan_idx_ff   <= scan_idx_in;
      iss_idx_ff    <= scan_idx_ff;
      iss_last_ff   <= iss_last_in;
      rsp_n1_ff     <= rsp_n1_in;
      rsp_n2_ff     <= rsp_n2_in;
      rsp_border_ff <= rsp_border_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.nearest_seed = rsp_n1_ff;
   assign rsp_ch.second_seed  = rsp_n2_ff;
   assign rsp_ch.on_border    = rsp_border_ff;
endmodule

FILE: rtl/vtnb_ram.sv
// Simple dual-port RAM, registered read
module vtnb_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/vtnb_rem.sv
// Restoring remainder, one quotient bit per cycle
module vtnb_rem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [vtnb_pkg::COORD_W-1:0] dividend,
   input  logic [vtnb_pkg::DIM_W-1:0]   divisor,
   output logic                         done,
   output logic [vtnb_pkg::COORD_W-1:0] remainder
);
   import vtnb_pkg::*;

   logic [COORD_W-1:0]   rem_ff, rem_in;
   logic [REM_SHD_W-1:0] shd_ff, shd_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   // Trial subtract of the shifted divisor, then shift it down
   always_comb begin
      rem_in  = rem_ff;
      shd_in  = shd_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         shd_in = REM_SHD_W'(divisor) << (COORD_W - 1);
         cnt_in = REM_CNT_W'(COORD_W);
      end else if (cnt_ff != '0) begin
         if (REM_SHD_W'(rem_ff) >= shd_ff) begin
            rem_in = COORD_W'(REM_SHD_W'(rem_ff) - shd_ff);
         end
         shd_in  = shd_ff >> 1;
         cnt_in  = cnt_ff - REM_CNT_W'(1);
         done_in = (cnt_ff == REM_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      shd_ff <= shd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

FILE: rtl/vtnb_dist.sv
// Squared distance to one seed per cycle, keeps the two nearest
module vtnb_dist (
   input  logic                         clock,
   input  logic                         reset,
   input  vtnb_pkg::scan_ctl_type       ctl,
   input  logic [vtnb_pkg::COORD_W-1:0] query_col,
   input  logic [vtnb_pkg::COORD_W-1:0] query_row,
   input  logic [vtnb_pkg::COORD_W-1:0] seed_col,
   input  logic [vtnb_pkg::COORD_W-1:0] seed_row,
   output vtnb_pkg::scan_res_type       res
);
   import vtnb_pkg::*;

   logic [COORD_W-1:0] ax, ay;
   logic [SQ_W-1:0]    sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic               sq_valid_ff, sq_last_ff;
   logic [SEED_W-1:0]  sq_idx_ff;
   logic [DIST_W-1:0]  dist_sum;
   logic               first_ok_ff, first_ok_in, second_ok_ff, second_ok_in;
   logic [DIST_W-1:0]  best_d_ff, best_d_in, next_d_ff, next_d_in;
   logic [SEED_W-1:0]  best_i_ff, best_i_in, next_i_ff, next_i_in;
   logic               done_ff, done_in;

   // Stage 1: absolute differences and squares
   always_comb begin
      ax      = (query_col > seed_col) ? query_col - seed_col : seed_col - query_col;
      ay      = (query_row > seed_row) ? query_row - seed_row : seed_row - query_row;
      sq_x_in = SQ_W'(ax) * SQ_W'(ax);
      sq_y_in = SQ_W'(ay) * SQ_W'(ay);
   end

   // Stage 2: sum and insert into the two-best list; earlier seed wins ties
   always_comb begin
      dist_sum     = DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff);
      first_ok_in  = first_ok_ff;
      second_ok_in = second_ok_ff;
      best_d_in    = best_d_ff;
      best_i_in    = best_i_ff;
      next_d_in    = next_d_ff;
      next_i_in    = next_i_ff;
      done_in      = 1'b0;
      if (ctl.clear) begin
         first_ok_in  = 1'b0;
         second_ok_in = 1'b0;
      end else if (sq_valid_ff) begin
         done_in = sq_last_ff;
         if (!first_ok_ff || dist_sum < best_d_ff) begin
            next_d_in    = best_d_ff;
            next_i_in    = best_i_ff;
            second_ok_in = first_ok_ff;
            best_d_in    = dist_sum;
            best_i_in    = sq_idx_ff;
            first_ok_in  = 1'b1;
         end else if (!second_ok_ff || dist_sum < next_d_ff) begin
            next_d_in    = dist_sum;
            next_i_in    = sq_idx_ff;
            second_ok_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         first_ok_ff  <= 1'b0;
         second_ok_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         sq_valid_ff  <= ctl.valid;
         first_ok_ff  <= first_ok_in;
         second_ok_ff <= second_ok_in;
         done_ff      <= done_in;
      end
      sq_x_ff    <= sq_x_in;
      sq_y_ff    <= sq_y_in;
      sq_idx_ff  <= ctl.idx;
      sq_last_ff <= ctl.last;
      best_d_ff  <= best_d_in;
      best_i_ff  <= best_i_in;
      next_d_ff  <= next_d_in;
      next_i_ff  <= next_i_in;
   end

   assign res.done   = done_ff;
   assign res.first  = best_i_ff;
   assign res.second = second_ok_ff ? next_i_ff : '0;
endmodule

FILE: rtl/vtnb_check.sv
`include "voronoi_two_nearest_border_macros.svh"

// Port-level checks on the top level
module vtnb_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_op,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [vtnb_pkg::SEED_W-1:0]   rsp_nearest,
   input logic [vtnb_pkg::SEED_W-1:0]   rsp_second,
   input logic                          rsp_border
);
   import vtnb_pkg::*;

   // no response word right after reset
   `VTNB_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, $past(reset), !rsp_valid)

   // a query keeps the block busy
   `VTNB_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && (req_op == OP_QUERY), !req_ready)

   // a seed load never produces a word
   `VTNB_ASSERT_NEXT(a_load_silent, clock, reset, req_valid && req_ready && (req_op == OP_LOAD) && !rsp_valid, !rsp_valid)

   // stalled word holds
   `VTNB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_nearest) && $stable(rsp_second) && $stable(rsp_border))
endmodule

bind voronoi_two_nearest_border vtnb_check u_vtnb_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_op      (req_ch.op),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_nearest (rsp_ch.nearest_seed),
   .rsp_second  (rsp_ch.second_seed),
   .rsp_border  (rsp_ch.on_border)
);
